// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbsh_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// State encoding, round constants, initial hash words and round functions.
// ---------------------------------------------------------------------------
`default_nettype none

package sbsh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sbsh_state_t;

  localparam logic [31:0] INIT_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Packs message bytes into a 512-bit block and compresses it one round per
// cycle with a shared round unit, then pads and returns the eight digest words.
// ---------------------------------------------------------------------------
// Usage: message words enter on the msg channel (data_byte, byte_valid,
// end_of_message) with msg_valid and msg_ready. A word with byte_valid set
// adds one byte; end_of_message marks the final word, and a final word with
// byte_valid clear ends the message before it. A word with both flags clear
// is dropped. After a plain byte msg_ready stays high. The byte that fills a
// block holds msg_ready low through the 64 rounds in the round unit and the
// add into the chaining value. After the final word the block feeds the
// padding through the same byte path, one byte a cycle, up to the end of the
// block, then compresses it; when fewer than nine bytes remained, a second
// padded block follows, padded and compressed the same way.
// The digest then leaves on the digest channel as eight words, word 0 first,
// one per cycle while digest_ready is high; a stalled receiver holds the
// current word and no new message word is taken until word 7 is delivered.
// The APB port holds the eight initial hash words, sampled at the start of
// each message. Reset restores the standard initial words and idles the block.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher #(
  parameter int LENGTH_BITS = 64
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        msg_valid,
  output logic              msg_ready,
  input  wire  logic [7:0]  data_byte,
  input  wire  logic        byte_valid,
  input  wire  logic        end_of_message,
  output logic              digest_valid,
  input  wire  logic        digest_ready,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_number,
  output logic              final_word,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [4:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import sbsh_pkg::*;

  sbsh_state_t            state;
  sbsh_state_t            state_next;
  logic [31:0]            init_word [8];
  logic [31:0]            chain [8];
  logic [31:0]            work [8];
  logic [511:0]           block;
  logic [LENGTH_BITS-1:0] bit_length;
  logic [6:0]             fill;
  logic [5:0]             round_count;
  logic [2:0]             word_idx;
  logic                   msg_active;
  logic                   in_pad;
  logic                   sent_mark;
  logic                   pad_final;

  logic                   msg_take;
  logic                   item_used;
  logic                   digest_take;
  logic [7:0]             pad_byte;
  logic [63:0]            len_field;
  logic [2:0]             len_idx;
  logic [31:0]            w0;
  logic [31:0]            w1;
  logic [31:0]            w9;
  logic [31:0]            w14;
  logic [31:0]            w_new;
  logic [31:0]            t1;
  logic [31:0]            t2;

  assign pready      = 1'b1;
  assign prdata      = init_word[paddr[4:2]];
  assign msg_take    = msg_valid && msg_ready;
  assign item_used   = msg_take && (byte_valid || end_of_message);
  assign digest_take = digest_valid && digest_ready;

  assign digest_word = chain[word_idx];
  assign word_number = word_idx;
  assign final_word  = (word_idx == 3'd7);

  assign len_field = 64'(bit_length);
  assign len_idx   = ~fill[2:0];

  assign w0  = block[511:480];
  assign w1  = block[479:448];
  assign w9  = block[223:192];
  assign w14 = block[63:32];

  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign t1    = work[7] + big_sigma1(work[4]) + choose(work[4], work[5], work[6]) +
                 ROUND_K[round_count] + w0;
  assign t2    = big_sigma0(work[0]) + majority(work[0], work[1], work[2]);

  always_comb begin
    msg_ready    = (state == ST_IDLE);
    digest_valid = (state == ST_OUT);
    if (!sent_mark) begin
      pad_byte = PAD_MARK;
    end else if (pad_final && (fill >= 7'd56)) begin
      pad_byte = len_field[{len_idx, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_used) begin
          if (byte_valid && (fill == 7'd63)) begin
            state_next = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == 7'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_count == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!in_pad) begin
          state_next = ST_IDLE;
        end else if (sent_mark && pad_final) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (digest_take && (word_idx == 3'd7)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        init_word[i] <= INIT_IV[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      init_word[paddr[4:2]] <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length  <= '0;
      fill        <= '0;
      round_count <= '0;
      word_idx    <= '0;
      msg_active  <= 1'b0;
      in_pad      <= 1'b0;
      sent_mark   <= 1'b0;
      pad_final   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_used) begin
            if (!msg_active) begin
              msg_active <= 1'b1;
            end
            if (byte_valid) begin
              bit_length <= bit_length + LENGTH_BITS'(8);
              if (fill == 7'd63) begin
                fill        <= '0;
                round_count <= '0;
              end else begin
                fill <= fill + 7'd1;
              end
            end
            if (end_of_message) begin
              in_pad    <= 1'b1;
              sent_mark <= 1'b0;
              pad_final <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          if (!sent_mark) begin
            sent_mark <= 1'b1;
            pad_final <= (fill <= 7'd55);
          end
          if (fill == 7'd63) begin
            fill        <= '0;
            round_count <= '0;
          end else begin
            fill <= fill + 7'd1;
          end
        end
        ST_ROUND: begin
          round_count <= round_count + 6'd1;
        end
        ST_ADD: begin
          if (in_pad && sent_mark) begin
            pad_final <= 1'b1;
            word_idx  <= '0;
          end
        end
        ST_OUT: begin
          if (digest_take) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == 3'd7) begin
              msg_active <= 1'b0;
              in_pad     <= 1'b0;
              bit_length <= '0;
              fill       <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_used) begin
          if (!msg_active) begin
            for (int i = 0; i < 8; i++) begin
              chain[i] <= init_word[i];
            end
          end
          if (byte_valid) begin
            block <= {block[503:0], data_byte};
            if (fill == 7'd63) begin
              for (int i = 0; i < 8; i++) begin
                work[i] <= chain[i];
              end
            end
          end
        end
      end
      ST_PAD: begin
        block <= {block[503:0], pad_byte};
        if (fill == 7'd63) begin
          for (int i = 0; i < 8; i++) begin
            work[i] <= chain[i];
          end
        end
      end
      ST_ROUND: begin
        block   <= {block[479:0], w_new};
        work[7] <= work[6];
        work[6] <= work[5];
        work[5] <= work[4];
        work[4] <= work[3] + t1;
        work[3] <= work[2];
        work[2] <= work[1];
        work[1] <= work[0];
        work[0] <= t1 + t2;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_round_to_add, (state == ST_ROUND) && (round_count == 6'd63), state == ST_ADD, "Round sequence did not end in the add step.")
  `ASSERT_NEXT(a_full_block, item_used && byte_valid && (fill == 7'd63), (state == ST_ROUND) && (round_count == 6'd0), "Full block did not start compression.")
  `ASSERT_SAME(a_digest_blocks_input, digest_valid, !msg_ready && in_pad && pad_final, "Digest shown while input is open.")
  `ASSERT_NEXT(a_block_only_return, (state == ST_ADD) && !in_pad, (state == ST_IDLE) && msg_active, "Mid-message block did not return to idle.")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams byte messages into the hasher and checks every digest word against
// an independent SHA-256 computation kept alongside the run. Directed messages
// cover the empty message, end markers with and without a byte, ignored words
// and a change of initial words in the middle of a message. Random phases
// follow, with lengths around the block and padding limits, random initial
// words, sender bursts and gaps, receiver stalls and one long receiver stall.
// ---------------------------------------------------------------------------

module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 160;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 500;
  localparam int INIT_WORD_COUNT = 8;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int BOUNDARY_LENGTHS [7] = '{55, 56, 57, 63, 64, 65, 119};

  localparam logic [31:0] STANDARD_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum int {IV_STANDARD, IV_ZEROS, IV_ONES, IV_RANDOM} iv_pattern_t;
  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_MOSTLY} ready_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } msg_word_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  number;
    logic        last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sha256_byte_stream_hasher uut (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .data_byte(data_byte),
    .byte_valid(byte_valid),
    .end_of_message(end_of_message),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest_word(digest_word),
    .word_number(word_number),
    .final_word(final_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  msg_word_t     message_words[$];
  digest_entry_t expected_digest[$];

  logic [31:0] init_words [8];
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill = 0;
  logic [63:0] message_bits = 64'd0;
  bit          message_open = 1'b0;

  logic msg_fire = 1'b0;
  int   mismatch_count = 0;
  int   words_checked = 0;
  int   messages_hashed = 0;
  int   bytes_hashed = 0;
  int   items_queued = 0;
  int   words_ignored = 0;
  int   iv_loads = 0;
  int   hold_requests = 0;
  int   stall_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] wt;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    v = chain_words;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        s0 = rotr(sched[(t-15)&15], 7) ^ rotr(sched[(t-15)&15], 18) ^ (sched[(t-15)&15] >> 3);
        s1 = rotr(sched[(t-2)&15], 17) ^ rotr(sched[(t-2)&15], 19) ^ (sched[(t-2)&15] >> 10);
        wt = sched[t&15] + s0 + sched[(t-7)&15] + s1;
        sched[t&15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_words[i] = chain_words[i] + v[i];
    end
  endfunction

  function automatic void absorb_word(logic [7:0] b, logic has_byte, logic last);
    digest_entry_t e;
    if (!has_byte && !last) begin
      return;
    end
    if (!message_open) begin
      chain_words = init_words;
      message_bits = 64'd0;
      block_fill = 0;
      message_open = 1'b1;
    end
    if (has_byte) begin
      block_bytes[block_fill] = b;
      block_fill++;
      message_bits = message_bits + 64'd8;
      bytes_hashed++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!last) begin
      return;
    end
    block_bytes[block_fill] = PAD_BYTE;
    block_fill++;
    if (block_fill > 56) begin
      while (block_fill < 64) begin
        block_bytes[block_fill] = 8'h00;
        block_fill++;
      end
      compress_block();
      block_fill = 0;
    end
    while (block_fill < 56) begin
      block_bytes[block_fill] = 8'h00;
      block_fill++;
    end
    for (int i = 0; i < 8; i++) begin
      block_bytes[56+i] = message_bits[63-8*i -: 8];
    end
    compress_block();
    for (int i = 0; i < 8; i++) begin
      e.value = chain_words[i];
      e.number = 3'(i);
      e.last = (i == 7);
      expected_digest.push_back(e);
    end
    block_fill = 0;
    message_bits = 64'd0;
    message_open = 1'b0;
    messages_hashed++;
  endfunction

  task automatic report_mismatch(string what, digest_entry_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch (%s): expected %08h num %0d final %0b, got %08h num %0d final %0b",
               what, want.value, want.number, want.last, digest_word, word_number, final_word);
    end
  endtask

  // Samples both channels at the rising edge and checks each digest word.
  always @(posedge clk) begin : monitor
    digest_entry_t want;
    if (rst) begin
      msg_fire <= 1'b0;
    end else begin
      msg_fire <= msg_valid && msg_ready;
      if (msg_valid && msg_ready) begin
        absorb_word(data_byte, byte_valid, end_of_message);
      end
      if (digest_valid && digest_ready) begin
        words_checked++;
        if (expected_digest.size() == 0) begin
          want = '{value: 32'd0, number: 3'd0, last: 1'b0};
          report_mismatch("no word expected", want);
        end else begin
          want = expected_digest.pop_front();
          if (digest_word !== want.value || word_number !== want.number ||
              final_word !== want.last) begin
            report_mismatch("wrong field", want);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (digest_valid && digest_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL sha256_byte_stream_hasher");
        $finish;
      end
    end
  end

  // The sender offers words in bursts, with random gaps between them.
  always @(negedge clk) begin : sender
    msg_word_t w;
    int burst_left;
    int gap_left;
    if (rst) begin
      msg_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else if (!msg_valid || msg_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        msg_valid <= 1'b0;
      end else if (message_words.size() > 0) begin
        w = message_words.pop_front();
        data_byte <= w.data;
        byte_valid <= w.has_byte;
        end_of_message <= w.last;
        msg_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        msg_valid <= 1'b0;
      end
    end
  end

  // The receiver switches between stall patterns and honors long hold requests.
  always @(negedge clk) begin : receiver
    ready_mode_t mode;
    int mode_left;
    int hold_left;
    int holds_served;
    int tick;
    if (rst) begin
      digest_ready <= 1'b0;
      mode = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      holds_served = 0;
      tick = 0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        digest_ready <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS: digest_ready <= 1'b1;
          READY_RANDOM: digest_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE: digest_ready <= (tick % 3 == 0);
          default: digest_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic push_word(logic [7:0] b, logic has_byte, logic last);
    msg_word_t w;
    w.data = b;
    w.has_byte = has_byte;
    w.last = last;
    message_words.push_back(w);
    if (has_byte || last) begin
      items_queued++;
    end else begin
      words_ignored++;
    end
  endtask

  task automatic queue_message(int len);
    bit close_on_byte;
    close_on_byte = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      push_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (len == 0 || !close_on_byte) begin
      push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic drain_and_settle();
    do begin
      @(posedge clk);
    end while (message_words.size() != 0 || msg_valid || expected_digest.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_init_word(int idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    init_words[idx] = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_init_words(iv_pattern_t pattern);
    logic [31:0] value;
    for (int i = 0; i < INIT_WORD_COUNT; i++) begin
      case (pattern)
        IV_STANDARD: value = STANDARD_IV[i];
        IV_ZEROS: value = 32'h0000_0000;
        IV_ONES: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      write_init_word(i, value);
    end
    iv_loads++;
  endtask

  initial begin
    int phase;
    int len;
    int pick;
    init_words = STANDARD_IV;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message, an ignored word, then messages closed with and without a byte.
    push_word(8'h5a, 1'b0, 1'b1);
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'ha5, 1'b1, 1'b0);
    push_word(8'h3c, 1'b0, 1'b1);
    drain_and_settle();

    // New initial words arrive while a message is open and apply to the next one.
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h7f, 1'b1, 1'b0);
    drain_and_settle();
    program_init_words(IV_ONES);
    push_word(8'hfe, 1'b1, 1'b0);
    push_word(8'h10, 1'b1, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    drain_and_settle();

    program_init_words(IV_ZEROS);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    drain_and_settle();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase == 0) begin
        program_init_words(IV_STANDARD);
        hold_requests++;
      end else if ($urandom_range(0, 2) == 0) begin
        program_init_words(iv_pattern_t'($urandom_range(0, 3)));
      end
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          len = $urandom_range(0, 12);
        end else if (pick < 17) begin
          len = BOUNDARY_LENGTHS[$urandom_range(0, 6)];
        end else begin
          len = $urandom_range(0, 130);
        end
        // Short messages keep the input busy while the receiver holds off.
        if (phase == 0) begin
          len = len % 9;
        end
        queue_message(len);
      end
      drain_and_settle();
      phase++;
    end

    $display("Hashed %0d messages (%0d bytes, %0d ignored words) under %0d initial-word loads.",
             messages_hashed, bytes_hashed, words_ignored, iv_loads);
    $display("Checked %0d digest words over %0d phases with one long receiver hold.",
             words_checked, phase);
    if (mismatch_count == 0) begin
      $display("PASS sha256_byte_stream_hasher");
    end else begin
      $display("FAIL sha256_byte_stream_hasher");
    end
    $finish;
  end

endmodule

// ===== sha256_byte_stream_hasher.f =====
+incdir+rtl
rtl/sbsh_pkg.sv
rtl/sha256_byte_stream_hasher.sv
bench/tb.sv
